/* src/clne_pkg.sv */
// ----------------------------------------------------------------------------
// clne_pkg
// Shared types, constants and tables for the 4-bit character LCD engine.
// ----------------------------------------------------------------------------
`default_nettype none

package clne_pkg;

  // Request opcodes (s_tuser)
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_DATA   = 3'd2;
  localparam logic [2:0] OP_NUMBER = 3'd3;
  localparam logic [2:0] OP_CURSOR = 3'd4;
  localparam logic [2:0] OP_SHIFT  = 3'd5;

  // Sizing
  localparam int MAX_DIGITS  = 10;
  localparam int MAX_SHIFTS  = 31;
  localparam int CNT_W       = 5;
  localparam int DIG_IDX_W   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int Q_DEPTH     = 2;
  localparam int QPTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 8;

  // Display commands
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0F;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
  localparam logic [7:0] CMD_SHIFT_RIGHT  = 8'h1C;
  localparam logic [7:0] CMD_SHIFT_LEFT   = 8'h18;
  localparam logic [3:0] INIT_NIBBLE      = 4'h2;
  localparam logic [7:0] ASCII_ZERO       = 8'h30;

  // floor(v / 10) == (v * DIV10_RECIP) >> DIV10_SHIFT for any 32-bit v
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  typedef enum logic [1:0] {
    K_INIT,
    K_BYTE,
    K_NUM
  } clne_kind_t;

  // One classified request in the queue
  typedef struct packed {
    clne_kind_t        kind;
    logic              rs;
    logic [7:0]        byte_val;
    logic [31:0]       num;
    logic [CNT_W-1:0]  cnt;      // bytes left after the first one
  } clne_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } clne_qstat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_LONE,
    S_HI,
    S_LO
  } clne_state_t;

  // Row base addresses
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    case (row)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      2'd3:    b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Init command bytes, indexed by how many are still left after this one
  function automatic logic [7:0] init_seq(input logic [1:0] left);
    logic [7:0] b;
    case (left)
      2'd3:    b = CMD_FUNCTION_SET;
      2'd2:    b = CMD_DISPLAY_ON;
      2'd1:    b = CMD_CLEAR;
      2'd0:    b = CMD_ENTRY_MODE;
      default: b = CMD_ENTRY_MODE;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* src/char_lcd_nibble_command_engine_unit.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_command_engine_unit
// 4-bit character LCD command engine: requests in, nibble transfers out.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_*       in   tuser: op; tdata: byte, number, row, column, dir, count
// m_*       out  tuser: register select; tdata: nibble; tlast: last nibble
//
// The sequencer takes a request from the queue, then sends its nibbles as m_*
// accepts them. Number requests first go through the divide-by-ten unit, one
// multiply and one quotient/remainder step per decimal digit, before output.
// Rows above three, zero shift counts and unused opcodes give no transfer.
// A two-entry queue lets new requests in while the back part is busy or m_*
// is stalled. Reset is synchronous and clears the queue and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_command_engine_unit
  import clne_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [7:0] byte_value, [39:8] number_value, [42:40] row_index,
  // [47:43] column_index, [48] shift_left, [53:49] shift_count
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // [2:0] op
  input  wire logic [2:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [3:0] nibble
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // [0] register_select
  output logic                       m_tuser,
  output logic                       m_tlast
);

  logic        push;
  clne_entry_t push_entry;
  logic        pop;
  clne_entry_t head;
  clne_qstat_t qstat;

  clne_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  clne_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  clne_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

/* src/clne_front.sv */
// ----------------------------------------------------------------------------
// clne_front
// Accepts requests, classifies them and pushes work records into the queue.
// Requests that give no transfer are accepted and dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module clne_front
  import clne_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [IN_DATA_W-1:0] s_tdata,
  input  wire logic [2:0]           s_tuser,
  input  wire clne_qstat_t          qstat,
  output logic                      push,
  output clne_entry_t               push_entry
);

  logic [7:0]       byte_value;
  logic [31:0]      number_value;
  logic [2:0]       row_index;
  logic [4:0]       column_index;
  logic             shift_left;
  logic [4:0]       shift_count;
  logic [CNT_W-1:0] shift_sat;
  logic             keep;

  // Unpack request fields
  assign byte_value   = s_tdata[7:0];
  assign number_value = s_tdata[39:8];
  assign row_index    = s_tdata[42:40];
  assign column_index = s_tdata[47:43];
  assign shift_left   = s_tdata[48];
  assign shift_count  = s_tdata[53:49];

  assign s_tready = !qstat.full;

  // Clamp the repeat count
  always_comb begin
    if (32'(shift_count) > MAX_SHIFTS) begin
      shift_sat = CNT_W'(MAX_SHIFTS);
    end else begin
      shift_sat = CNT_W'(shift_count);
    end
  end

  // Classify
  always_comb begin
    keep                = 1'b0;
    push_entry.kind     = K_BYTE;
    push_entry.rs       = 1'b0;
    push_entry.byte_val = byte_value;
    push_entry.num      = number_value;
    push_entry.cnt      = '0;
    case (s_tuser)
      OP_INIT: begin
        keep            = 1'b1;
        push_entry.kind = K_INIT;
        push_entry.cnt  = CNT_W'(3);
      end
      OP_CMD: begin
        keep = 1'b1;
      end
      OP_DATA: begin
        keep          = 1'b1;
        push_entry.rs = 1'b1;
      end
      OP_NUMBER: begin
        keep            = 1'b1;
        push_entry.kind = K_NUM;
        push_entry.rs   = 1'b1;
      end
      OP_CURSOR: begin
        keep                = !row_index[2];
        push_entry.byte_val = CMD_SET_DDRAM + row_base(row_index[1:0])
                              + {3'b000, column_index};
      end
      OP_SHIFT: begin
        keep                = (shift_sat != '0);
        push_entry.byte_val = shift_left ? CMD_SHIFT_LEFT : CMD_SHIFT_RIGHT;
        push_entry.cnt      = shift_sat - CNT_W'(1);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = s_tvalid && s_tready && keep;

  // Never push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("push while queue full");

  // Cursor requests on rows above three never reach the queue
  a_row_drop: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tuser == OP_CURSOR && row_index[2]) |-> !push)
    else $error("cursor request on invalid row pushed");

  // Shift requests push with the clamped count minus one
  a_shift_cnt: assert property (@(posedge clk) disable iff (rst)
    (push && s_tuser == OP_SHIFT) |-> (push_entry.cnt == shift_sat - CNT_W'(1)))
    else $error("shift repeat count wrong");

endmodule

`default_nettype wire

/* src/clne_queue.sv */
// ----------------------------------------------------------------------------
// clne_queue
// Short FIFO of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module clne_queue
  import clne_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire clne_entry_t push_entry,
  input  wire logic        pop,
  output clne_entry_t      head,
  output clne_qstat_t      qstat
);

  clne_entry_t        entries [Q_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_pop;

  assign qstat.full  = (count == QCNT_W'(Q_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_pop      = pop && !qstat.empty;
  assign head        = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push && !qstat.full) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !qstat.full) begin
        wr_ptr <= (wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push && !qstat.full, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Fill count stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(Q_DEPTH))
    else $error("queue count out of range");

  // Pop on empty queue is a back-end slip
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // A lone push raises the count by one
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !qstat.full && !do_pop) |=> count == $past(count) + QCNT_W'(1))
    else $error("count did not follow push");

endmodule

`default_nettype wire

/* src/clne_back.sv */
// ----------------------------------------------------------------------------
// clne_back
// Sequencer that turns queued work records into nibble transfers, with a
// divide-by-ten unit for decimal conversion and a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module clne_back
  import clne_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire clne_entry_t           head,
  input  wire clne_qstat_t           qstat,
  output logic                       pop,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tuser,
  output logic                       m_tlast
);

  clne_state_t          state, state_next;
  clne_kind_t           kind, kind_next;
  logic                 rs, rs_next;
  logic [7:0]           byte_r, byte_r_next;
  logic [31:0]          num, num_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [DIG_IDX_W-1:0] dn, dn_next;
  logic [63:0]          prod, prod_next;
  logic [3:0]           digits [MAX_DIGITS];
  logic                 dig_we;
  logic [3:0]           dig_wdata;

  logic                 out_free;
  logic                 load;
  logic [3:0]           nib_next;
  logic                 last_next;
  logic [3:0]           nibble;
  logic [7:0]           cur_byte;
  logic [31:0]          quot;
  logic [31:0]          rem_full;

  assign out_free = !m_tvalid || m_tready;

  // Divide by ten from the registered product
  assign quot     = {3'b000, prod[63:DIV10_SHIFT]};
  assign rem_full = num - ((quot << 3) + (quot << 1));

  // Byte now being sent
  always_comb begin
    case (kind)
      K_INIT:  cur_byte = init_seq(cnt[1:0]);
      K_NUM:   cur_byte = ASCII_ZERO | {4'h0, digits[cnt[DIG_IDX_W-1:0]]};
      default: cur_byte = byte_r;
    endcase
  end

  // Next state and outputs
  always_comb begin
    state_next  = state;
    kind_next   = kind;
    rs_next     = rs;
    byte_r_next = byte_r;
    num_next    = num;
    cnt_next    = cnt;
    dn_next     = dn;
    prod_next   = prod;
    pop         = 1'b0;
    load        = 1'b0;
    nib_next    = cur_byte[7:4];
    last_next   = 1'b0;
    dig_we      = 1'b0;
    dig_wdata   = rem_full[3:0];
    case (state)
      S_IDLE: begin
        if (!qstat.empty) begin
          pop         = 1'b1;
          kind_next   = head.kind;
          rs_next     = head.rs;
          byte_r_next = head.byte_val;
          num_next    = head.num;
          cnt_next    = head.cnt;
          dn_next     = '0;
          case (head.kind)
            K_INIT:  state_next = S_LONE;
            K_NUM:   state_next = S_MUL;
            default: state_next = S_HI;
          endcase
        end
      end
      S_MUL: begin
        prod_next  = 64'(num) * 64'(DIV10_RECIP);
        state_next = S_DIV;
      end
      S_DIV: begin
        dig_we   = 1'b1;
        num_next = quot;
        if (quot == '0 || dn == DIG_IDX_W'(MAX_DIGITS - 1)) begin
          cnt_next   = CNT_W'(dn);
          state_next = S_HI;
        end else begin
          dn_next    = dn + DIG_IDX_W'(1);
          state_next = S_MUL;
        end
      end
      S_LONE: begin
        if (out_free) begin
          load       = 1'b1;
          nib_next   = INIT_NIBBLE;
          state_next = S_HI;
        end
      end
      S_HI: begin
        if (out_free) begin
          load       = 1'b1;
          nib_next   = cur_byte[7:4];
          state_next = S_LO;
        end
      end
      S_LO: begin
        if (out_free) begin
          load      = 1'b1;
          nib_next  = cur_byte[3:0];
          last_next = (cnt == '0);
          if (cnt == '0) begin
            state_next = S_IDLE;
          end else begin
            cnt_next   = cnt - CNT_W'(1);
            state_next = S_HI;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    kind   <= kind_next;
    rs     <= rs_next;
    byte_r <= byte_r_next;
    num    <= num_next;
    cnt    <= cnt_next;
    dn     <= dn_next;
    prod   <= prod_next;
  end

  // Digit store, least significant digit at index zero
  always_ff @(posedge clk) begin
    if (dig_we) begin
      digits[dn] <= dig_wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nibble  <= nib_next;
      m_tuser <= (state == S_LONE) ? 1'b0 : rs;
      m_tlast <= last_next;
    end
  end

  assign m_tdata = {(OUT_DATA_W - 4)'(0), nibble};

  // Divide step always follows a multiply step
  a_div_after_mul: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> $past(state) == S_MUL)
    else $error("divide step without product");

  // Digit index stays inside the digit store
  a_dn_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_DIV) |-> dn <= DIG_IDX_W'(MAX_DIGITS - 1))
    else $error("digit index out of range");

  // A last nibble ends the request and returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load && last_next) |=> state == S_IDLE)
    else $error("last nibble without end of request");

  // Never load over a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!m_tvalid || m_tready))
    else $error("output overwritten");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 4-bit character LCD command engine. Requests
// go in on s_*; a local model expands each accepted request into the nibble
// transfers it should cause, and every transfer taken from m_* is compared
// in order against that list. Directed corner requests come first, then
// random requests under changing back-pressure, a long receiver hold-off
// that fills the engine, and a pause that lets the engine drain.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import clne_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_PRINTS   = 50;

  // Opcodes the engine does not decode
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // DDRAM start address of each display row
  localparam logic [7:0] ROW_ADDR [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  byte_value;
    logic [31:0] number_value;
    logic [2:0]  row_index;
    logic [4:0]  column_index;
    logic        shift_left;
    logic [4:0]  shift_count;
  } lcd_req_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       last;
  } lcd_nibble_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // [7:0] byte_value, [39:8] number_value, [42:40] row_index,
  // [47:43] column_index, [48] shift_left, [53:49] shift_count
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // [2:0] op
  logic [2:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [3:0] nibble
  logic [OUT_DATA_W-1:0] m_tdata;
  // [0] register_select
  logic                  m_tuser;
  logic                  m_tlast;

  lcd_nibble_t pending_nibbles[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_ticket = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  char_lcd_nibble_command_engine_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver hold-off counter; a new ticket starts a long stall
  always @(posedge clk) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver ready
  always @(posedge clk) begin
    m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTS)
      $display("MISMATCH @%0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Compare each transfer against the oldest expected nibble
  always @(posedge clk) begin
    lcd_nibble_t           want;
    logic [OUT_DATA_W-1:0] want_data;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_nibbles.size() == 0) begin
        report_mismatch($sformatf("unexpected nibble rs=%0b data=%0h last=%0b",
                                  m_tuser, m_tdata, m_tlast));
      end else begin
        want = pending_nibbles.pop_front();
        want_data = '0;
        want_data[3:0] = want.nib;
        if (m_tuser !== want.rs)
          report_mismatch($sformatf("rs got %0b want %0b", m_tuser, want.rs));
        if (m_tdata !== want_data)
          report_mismatch($sformatf("nibble got %0h want %0h", m_tdata, want_data));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", m_tlast, want.last));
      end
    end
  end

  // Expected transfer list
  task automatic push_nibble(input logic rs, input logic [3:0] nib);
    lcd_nibble_t n;
    n.rs = rs;
    n.nib = nib;
    n.last = 1'b0;
    pending_nibbles.push_back(n);
  endtask

  task automatic push_byte(input logic rs, input logic [7:0] value);
    push_nibble(rs, value[7:4]);
    push_nibble(rs, value[3:0]);
  endtask

  // Expand one request into the nibbles the display should receive
  task automatic expand_request(input lcd_req_t r);
    int          first;
    int          ndig;
    logic [31:0] v;
    logic [3:0]  digits [MAX_DIGITS];
    logic [7:0]  addr;
    logic [4:0]  reps;
    lcd_nibble_t tail;
    first = pending_nibbles.size();
    case (r.op)
      OP_INIT: begin
        push_nibble(1'b0, INIT_NIBBLE);
        push_byte(1'b0, CMD_FUNCTION_SET);
        push_byte(1'b0, CMD_DISPLAY_ON);
        push_byte(1'b0, CMD_CLEAR);
        push_byte(1'b0, CMD_ENTRY_MODE);
      end
      OP_CMD:  push_byte(1'b0, r.byte_value);
      OP_DATA: push_byte(1'b1, r.byte_value);
      OP_NUMBER: begin
        v = r.number_value;
        if (v == 0) begin
          push_byte(1'b1, ASCII_ZERO);
        end else begin
          ndig = 0;
          while (v != 0 && ndig < MAX_DIGITS) begin
            digits[ndig] = 4'(v % 10);
            v = v / 10;
            ndig++;
          end
          for (int i = ndig - 1; i >= 0; i--)
            push_byte(1'b1, ASCII_ZERO + {4'h0, digits[i]});
        end
      end
      OP_CURSOR: begin
        if (r.row_index < 3'd4) begin
          addr = CMD_SET_DDRAM + ROW_ADDR[r.row_index[1:0]] + {3'b000, r.column_index};
          push_byte(1'b0, addr);
        end
      end
      OP_SHIFT: begin
        reps = (r.shift_count > 5'(MAX_SHIFTS)) ? 5'(MAX_SHIFTS) : r.shift_count;
        for (int k = 0; k < reps; k++)
          push_byte(1'b0, r.shift_left ? CMD_SHIFT_LEFT : CMD_SHIFT_RIGHT);
      end
      default: ;
    endcase
    if (pending_nibbles.size() > first) begin
      tail = pending_nibbles[pending_nibbles.size() - 1];
      tail.last = 1'b1;
      pending_nibbles[pending_nibbles.size() - 1] = tail;
    end
  endtask

  // Offer one request, wait for the handshake, record what it should cause
  task automatic send_request(input lcd_req_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.op;
    s_tdata  <= {2'b00, r.shift_count, r.shift_left, r.column_index,
                 r.row_index, r.number_value, r.byte_value};
    do @(posedge clk); while (!s_tready);
    expand_request(r);
  endtask

  function automatic lcd_req_t make_request(input logic [2:0] op, input logic [7:0] b,
                                            input logic [31:0] num, input logic [2:0] row,
                                            input logic [4:0] col, input logic dir,
                                            input logic [4:0] cnt);
    lcd_req_t r;
    r.op = op;
    r.byte_value = b;
    r.number_value = num;
    r.row_index = row;
    r.column_index = col;
    r.shift_left = dir;
    r.shift_count = cnt;
    return r;
  endfunction

  function automatic logic [31:0] random_number();
    logic [31:0] v;
    int          pick;
    int          scale;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      v = $urandom;
    end else if (pick < 50) begin
      v = $urandom_range(0, 9);
    end else if (pick < 70) begin
      v = $urandom_range(0, 99999);
    end else if (pick < 85) begin
      // values with trailing zeros
      v = $urandom_range(1, 9);
      scale = $urandom_range(1, 9);
      repeat (scale) v = v * 10;
    end else if (pick < 93) begin
      v = 32'hFFFF_FFFF - $urandom_range(0, 20);
    end else begin
      v = 32'd1_000_000_000 + $urandom_range(0, 20) - 10;
    end
    return v;
  endfunction

  // Every field is filled at random, then the op-relevant ones are shaped
  function automatic lcd_req_t random_request();
    lcd_req_t r;
    int       pick;
    r.byte_value   = 8'($urandom);
    r.number_value = $urandom;
    r.row_index    = 3'($urandom);
    r.column_index = 5'($urandom);
    r.shift_left   = 1'($urandom);
    r.shift_count  = 5'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      r.op = OP_INIT;
    end else if (pick < 25) begin
      r.op = OP_CMD;
    end else if (pick < 40) begin
      r.op = OP_DATA;
    end else if (pick < 65) begin
      r.op = OP_NUMBER;
      r.number_value = random_number();
    end else if (pick < 80) begin
      r.op = OP_CURSOR;
      if ($urandom_range(0, 3) != 0)
        r.column_index = 5'($urandom_range(0, 20));
    end else if (pick < 97) begin
      r.op = OP_SHIFT;
      if ($urandom_range(0, 3) != 0)
        r.shift_count = 5'($urandom_range(0, 3));
    end else begin
      r.op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
    end
    return r;
  endfunction

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  // Corner requests: every op, field extremes, requests that give nothing
  task automatic test_directed();
    send_request(make_request(OP_INIT,   8'h00, 32'd0,          3'd0, 5'd0,  1'b0, 5'd0));
    send_request(make_request(OP_CMD,    8'h00, 32'd0,          3'd0, 5'd0,  1'b0, 5'd0));
    send_request(make_request(OP_CMD,    8'hFF, 32'd0,          3'd0, 5'd0,  1'b0, 5'd0));
    send_request(make_request(OP_DATA,   8'h00, 32'd0,          3'd0, 5'd0,  1'b0, 5'd0));
    send_request(make_request(OP_DATA,   8'hFF, 32'd0,          3'd0, 5'd0,  1'b0, 5'd0));
    send_request(make_request(OP_NUMBER, 8'h00, 32'd0,          3'd0, 5'd0,  1'b0, 5'd0));
    send_request(make_request(OP_NUMBER, 8'h00, 32'd1,          3'd0, 5'd0,  1'b0, 5'd0));
    send_request(make_request(OP_NUMBER, 8'h00, 32'd100,        3'd0, 5'd0,  1'b0, 5'd0));
    send_request(make_request(OP_NUMBER, 8'h00, 32'd1000000000, 3'd0, 5'd0,  1'b0, 5'd0));
    send_request(make_request(OP_NUMBER, 8'h00, 32'hFFFF_FFFF,  3'd0, 5'd0,  1'b0, 5'd0));
    send_request(make_request(OP_CURSOR, 8'h00, 32'd0,          3'd0, 5'd0,  1'b0, 5'd0));
    send_request(make_request(OP_CURSOR, 8'h00, 32'd0,          3'd1, 5'd7,  1'b0, 5'd0));
    send_request(make_request(OP_CURSOR, 8'h00, 32'd0,          3'd2, 5'd19, 1'b0, 5'd0));
    send_request(make_request(OP_CURSOR, 8'h00, 32'd0,          3'd3, 5'd20, 1'b0, 5'd0));
    send_request(make_request(OP_CURSOR, 8'h00, 32'd0,          3'd3, 5'd31, 1'b0, 5'd0));
    send_request(make_request(OP_CURSOR, 8'h00, 32'd0,          3'd4, 5'd3,  1'b0, 5'd0));
    send_request(make_request(OP_CURSOR, 8'h00, 32'd0,          3'd7, 5'd31, 1'b0, 5'd0));
    send_request(make_request(OP_SHIFT,  8'h00, 32'd0,          3'd0, 5'd0,  1'b1, 5'd0));
    send_request(make_request(OP_SHIFT,  8'h00, 32'd0,          3'd0, 5'd0,  1'b0, 5'd1));
    send_request(make_request(OP_SHIFT,  8'h00, 32'd0,          3'd0, 5'd0,  1'b1, 5'd31));
    send_request(make_request(OP_SPARE6, 8'hFF, 32'hFFFF_FFFF,  3'd7, 5'd31, 1'b1, 5'd31));
    send_request(make_request(OP_SPARE7, 8'hFF, 32'hFFFF_FFFF,  3'd7, 5'd31, 1'b1, 5'd31));
    send_request(make_request(OP_DATA,   8'h5A, 32'd0,          3'd0, 5'd0,  1'b0, 5'd0));
  endtask

  // Random requests; unused opcodes do not count toward n
  task automatic test_random_mix(input int n);
    lcd_req_t r;
    int       sent;
    sent = 0;
    while (sent < n) begin
      r = random_request();
      send_request(r);
      if (r.op != OP_SPARE6 && r.op != OP_SPARE7)
        sent++;
    end
  endtask

  // Receiver stalls for a long stretch while long requests keep coming
  task automatic test_receiver_holdoff();
    int saved_tx;
    saved_tx = tx_idle_pct;
    tx_idle_pct = 0;
    hold_ticket <= hold_ticket + 1;
    repeat (12) send_request(make_request(OP_NUMBER, 8'($urandom), random_number(),
                                          3'($urandom), 5'($urandom), 1'($urandom),
                                          5'($urandom)));
    tx_idle_pct = saved_tx;
  endtask

  // Sender stops until every expected nibble has come out
  task automatic test_drain_pause();
    repeat (6) send_request(random_request());
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_nibbles.size() != 0) @(posedge clk);
    repeat (4) send_request(random_request());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idle(22, 65);
    test_directed();
    test_random_mix(100);
    test_receiver_holdoff();
    test_drain_pause();

    set_idle(65, 22);
    test_random_mix(100);

    set_idle(0, 0);
    test_random_mix(100);

    // drain and settle
    s_tvalid <= 1'b0;
    while (pending_nibbles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
